### hw/rtl/edd_pkg.sv
// Shared types, codes and arithmetic helpers for the error-diffusion dither core.
package edd_pkg;

  typedef enum logic [11:0] {
    ST_CLEAR  = 12'b0000_0000_0001,
    ST_IDLE   = 12'b0000_0000_0010,
    ST_START  = 12'b0000_0000_0100,
    ST_FLUSH  = 12'b0000_0000_1000,
    ST_FETCH  = 12'b0000_0001_0000,
    ST_FWAIT  = 12'b0000_0010_0000,
    ST_STEP   = 12'b0000_0100_0000,
    ST_DIV    = 12'b0000_1000_0000,
    ST_ROUND  = 12'b0001_0000_0000,
    ST_MUL    = 12'b0010_0000_0000,
    ST_SHARE  = 12'b0100_0000_0000,
    ST_UPDATE = 12'b1000_0000_0000
  } state_e;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] REG_LINE_WIDTH    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LEVEL_BITS    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_KERNEL_SELECT = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_VALUE     = 2'd3;

  localparam logic [1:0] KERN_FS     = 2'd0;
  localparam logic [1:0] KERN_JJN    = 2'd1;
  localparam logic [1:0] KERN_SIERRA = 2'd2;
  localparam logic [1:0] KERN_ATK    = 2'd3;

  // Tap order: [0] right+1, [1] right+2, [2..6] next row dx -2..2, [7..11] row after dx -2..2
  typedef logic [11:0][2:0] kern_w_t;

  function automatic kern_w_t kernel_weights(input logic [1:0] ksel);
    kern_w_t w;
    case (ksel)
      KERN_FS: begin
        w = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd5, 3'd3, 3'd0, 3'd0, 3'd7};
      end
      KERN_JJN: begin
        w = {3'd1, 3'd3, 3'd5, 3'd3, 3'd1, 3'd3, 3'd5, 3'd7, 3'd5, 3'd3, 3'd5, 3'd7};
      end
      KERN_SIERRA: begin
        w = {3'd0, 3'd2, 3'd3, 3'd2, 3'd0, 3'd2, 3'd4, 3'd5, 3'd4, 3'd2, 3'd3, 3'd5};
      end
      default: begin
        w = {3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd0, 3'd1, 3'd1};
      end
    endcase
    return w;
  endfunction

  // ceil(2^16 / (2^bits - 1)) for bits 1..6, else 0; exact floor division for 8-bit dividends
  function automatic logic [16:0] step_recip(input logic [3:0] bits);
    logic [16:0] r;
    case (bits)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd21846;
      4'd3:    r = 17'd9363;
      4'd4:    r = 17'd4370;
      4'd5:    r = 17'd2115;
      4'd6:    r = 17'd1041;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // err * w / D truncated toward zero; divide by 48 as /16 then reciprocal /3
  function automatic logic signed [11:0] share(input logic signed [9:0] err,
                                               input logic [2:0] wgt,
                                               input logic [1:0] ksel);
    logic [7:0]         mag;
    logic [10:0]        prod;
    logic [6:0]         b;
    logic [14:0]        t;
    logic [7:0]         res;
    logic signed [11:0] s;
    mag  = err[9] ? 8'(-err) : 8'(err);
    prod = 11'(mag) * 11'(wgt);
    b    = 7'(prod >> 4);
    t    = 15'(b) * 15'(171);
    case (ksel)
      KERN_FS:     res = 8'(prod >> 4);
      KERN_JJN:    res = 8'(t >> 9);
      KERN_SIERRA: res = 8'(prod >> 5);
      default:     res = 8'(prod >> 3);
    endcase
    s = $signed({4'b0000, res});
    return err[9] ? -s : s;
  endfunction

endpackage

### hw/rtl/error_diffusion_dither_core.sv
// Error-diffusion dither core: error row memory, window of five columns, quantizer.
//
// Grey pixels arrive in raster order on the s_axis channel (tdata = pixel,
// tuser = frame start); dithered levels leave on m_axis, one per pixel, in order.
// Registers are written over the cfg channel (always ready); the user must write
// them only while no pixel is in flight, which the block does not enforce. Carried
// errors for the next two rows live in one memory of MAX_WIDTH words, read and
// written at most once per mid-row pixel through a five-column window. The core
// works on one pixel at a time: the window refill walks five columns, reading
// from the memory those in the row but not yet held, and the quotient by the
// level step comes from a one-bit-per-cycle divider. A pixel that opens a row
// first writes back the previous row's window and then reads the extra columns.
// After reset, and on a pixel with frame start set, a clearing pass writes zero
// to all MAX_WIDTH memory words, one per cycle, before input is taken or the
// flagged pixel is handled. Results sit in an output register; a stalled
// receiver holds the next pixel's last step until that register frees, and no
// further pixel is taken in until that step completes.
module error_diffusion_dither_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] pixel_in
  input  logic                          s_axis_tuser,   // [0] frame_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] pixel_out
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [edd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [edd_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CKW = WW + 1;

  typedef struct packed {
    logic          vld;
    logic [AW-1:0] addr;
    logic [11:0]   nxt;
    logic [11:0]   aft;
  } slot_t;

  edd_pkg::state_e state_q, state_d;

  logic [11:0] lw_q;
  logic [3:0]  lb_q;
  logic [1:0]  ks_q;
  logic [7:0]  mv_q;

  logic [AW-1:0]      clr_q;
  logic               pend_q;
  logic [7:0]         pix_q;
  logic [AW-1:0]      col_q;
  logic [AW-1:0]      c_q;
  logic [2:0]         fl_q;
  logic [2:0]         fk_q;
  logic [AW-1:0]      rd_addr_q;
  slot_t              win_q [5];
  logic signed [11:0] take_q [3];
  logic signed [11:0] ahead_q [2];
  logic [7:0]         v_q;
  logic [7:0]         step_q;
  logic [7:0]         div_rem_q;
  logic [7:0]         div_quo_q;
  logic [2:0]         div_cnt_q;
  logic [7:0]         kq_q;
  logic [7:0]         q_q;
  logic signed [11:0] sh_q [12];
  logic               out_vld_q;
  logic [7:0]         out_q;

  logic [23:0]   err_mem [MAX_WIDTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [23:0]   mem_wdata;
  logic [23:0]   mem_rdata_q;

  logic [WW-1:0]      w_eff;
  logic [3:0]         bits_eff;
  logic [AW-1:0]      c_start;
  logic               in_acc;
  logic               go;
  logic               inr_f, need_rd, take_f;
  logic [CKW-1:0]     ck_f;
  logic signed [11:0] a0, a1, a2;
  logic signed [12:0] vs;
  logic [7:0]         v_sat;
  logic [24:0]        step_prod;
  logic [8:0]         div_rs;
  logic               div_bit;
  logic [7:0]         div_rem_n;
  logic [8:0]         k_rnd;
  logic [7:0]         n_lvl;
  logic [15:0]        q_prod;
  logic signed [9:0]  err;
  edd_pkg::kern_w_t   kw;
  slot_t              win_upd [5];
  logic               inr_u [5];
  logic [WW-1:0]      c_next;

  function automatic logic slot_in(input logic [AW-1:0] c, input logic [2:0] k,
                                   input logic [WW-1:0] w);
    logic [CKW-1:0] ck;
    ck = CKW'(c) + CKW'(k);
    return (ck >= CKW'(2)) && (ck < CKW'(w) + CKW'(2));
  endfunction

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      err_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= err_mem[mem_raddr];
    end
  end

  always_comb begin
    if (lw_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(lw_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(lw_q);
    end
    if (lb_q == 4'd0) begin
      bits_eff = 4'd1;
    end else if (lb_q > 4'd8) begin
      bits_eff = 4'd8;
    end else begin
      bits_eff = lb_q;
    end
  end

  assign c_start = (WW'(col_q) >= w_eff) ? '0 : col_q;
  assign s_axis_tready = (state_q == edd_pkg::ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign go = !out_vld_q || m_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = out_q;

  // window refill: load columns that are in the row but not yet held
  assign ck_f    = CKW'(c_q) + CKW'(fk_q);
  assign inr_f   = slot_in(c_q, fk_q, w_eff);
  assign need_rd = inr_f && !win_q[fk_q].vld;
  assign take_f  = (c_q == '0) || (fk_q == 3'd4);

  assign a0 = (c_q == '0) ? take_q[0] : ahead_q[0];
  assign a1 = (c_q == '0) ? take_q[1] : ahead_q[1];
  assign a2 = take_q[2];

  always_comb begin
    vs = $signed({5'b00000, pix_q}) + 13'(a0);
    if (vs < 0) begin
      v_sat = '0;
    end else if (vs > $signed({5'b00000, mv_q})) begin
      v_sat = mv_q;
    end else begin
      v_sat = vs[7:0];
    end
  end

  assign step_prod = 25'(mv_q) * 25'(edd_pkg::step_recip(bits_eff));

  assign div_rs    = {div_rem_q, div_quo_q[7]};
  assign div_bit   = (div_rs >= {1'b0, step_q});
  assign div_rem_n = div_bit ? 8'(div_rs - {1'b0, step_q}) : div_rs[7:0];

  assign n_lvl = 8'((9'd1 << bits_eff) - 9'd1);
  assign k_rnd = {1'b0, div_quo_q} + (({div_rem_q, 1'b0} > {1'b0, step_q}) ? 9'd1 : 9'd0);
  assign q_prod = 16'(kq_q) * 16'(step_q);

  assign err = $signed({2'b00, v_q}) - $signed({2'b00, q_q});
  assign kw = edd_pkg::kernel_weights(ks_q);

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      inr_u[k] = slot_in(c_q, 3'(k), w_eff);
      win_upd[k] = win_q[k];
      if (inr_u[k]) begin
        win_upd[k].nxt = win_q[k].nxt + sh_q[2 + k];
        win_upd[k].aft = win_q[k].aft + sh_q[7 + k];
      end
    end
  end

  assign c_next = WW'(c_q) + WW'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = AW'(ck_f - CKW'(2));
    case (state_q)
      edd_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      edd_pkg::ST_FLUSH: begin
        mem_we    = win_q[fl_q].vld;
        mem_waddr = win_q[fl_q].addr;
        mem_wdata = {win_q[fl_q].nxt, win_q[fl_q].aft};
      end
      edd_pkg::ST_FETCH: begin
        mem_re = need_rd;
      end
      edd_pkg::ST_UPDATE: begin
        mem_we    = go && win_q[0].vld;
        mem_waddr = win_q[0].addr;
        mem_wdata = {win_upd[0].nxt, win_upd[0].aft};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      edd_pkg::ST_CLEAR: begin
        if (clr_q == AW'(MAX_WIDTH - 1)) begin
          state_d = pend_q ? edd_pkg::ST_START : edd_pkg::ST_IDLE;
        end
      end
      edd_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = s_axis_tuser ? edd_pkg::ST_CLEAR : edd_pkg::ST_START;
        end
      end
      edd_pkg::ST_START: begin
        state_d = (c_start == '0) ? edd_pkg::ST_FLUSH : edd_pkg::ST_FETCH;
      end
      edd_pkg::ST_FLUSH: begin
        if (fl_q == 3'd4) begin
          state_d = edd_pkg::ST_FETCH;
        end
      end
      edd_pkg::ST_FETCH: begin
        if (need_rd) begin
          state_d = edd_pkg::ST_FWAIT;
        end else if (fk_q == 3'd4) begin
          state_d = edd_pkg::ST_STEP;
        end
      end
      edd_pkg::ST_FWAIT: begin
        state_d = (fk_q == 3'd4) ? edd_pkg::ST_STEP : edd_pkg::ST_FETCH;
      end
      edd_pkg::ST_STEP:  state_d = edd_pkg::ST_DIV;
      edd_pkg::ST_DIV: begin
        if (div_cnt_q == 3'd7) begin
          state_d = edd_pkg::ST_ROUND;
        end
      end
      edd_pkg::ST_ROUND: state_d = edd_pkg::ST_MUL;
      edd_pkg::ST_MUL:   state_d = edd_pkg::ST_SHARE;
      edd_pkg::ST_SHARE: state_d = edd_pkg::ST_UPDATE;
      edd_pkg::ST_UPDATE: begin
        if (go) begin
          state_d = edd_pkg::ST_IDLE;
        end
      end
      default: state_d = edd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= 12'd640;
      lb_q <= 4'd1;
      ks_q <= edd_pkg::KERN_FS;
      mv_q <= 8'd255;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        edd_pkg::REG_LINE_WIDTH:    lw_q <= cfg_data_i;
        edd_pkg::REG_LEVEL_BITS:    lb_q <= cfg_data_i[3:0];
        edd_pkg::REG_KERNEL_SELECT: ks_q <= cfg_data_i[1:0];
        edd_pkg::REG_MAX_VALUE:     mv_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= edd_pkg::ST_CLEAR;
      clr_q     <= '0;
      pend_q    <= 1'b0;
      pix_q     <= '0;
      col_q     <= '0;
      c_q       <= '0;
      fl_q      <= '0;
      fk_q      <= '0;
      rd_addr_q <= '0;
      v_q       <= '0;
      step_q    <= '0;
      div_rem_q <= '0;
      div_quo_q <= '0;
      div_cnt_q <= '0;
      kq_q      <= '0;
      q_q       <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
      for (int k = 0; k < 5; k++) win_q[k] <= '0;
      for (int k = 0; k < 3; k++) take_q[k] <= '0;
      for (int k = 0; k < 2; k++) ahead_q[k] <= '0;
      for (int k = 0; k < 12; k++) sh_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (m_axis_tready && (state_q != edd_pkg::ST_UPDATE)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        edd_pkg::ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAX_WIDTH - 1)) begin
            pend_q <= 1'b0;
          end
        end
        edd_pkg::ST_IDLE: begin
          if (in_acc) begin
            pix_q <= s_axis_tdata;
            if (s_axis_tuser) begin
              // drop every carried error and restart at column zero
              for (int k = 0; k < 5; k++) win_q[k] <= '0;
              for (int k = 0; k < 2; k++) ahead_q[k] <= '0;
              col_q  <= '0;
              clr_q  <= '0;
              pend_q <= 1'b1;
            end
          end
        end
        edd_pkg::ST_START: begin
          c_q  <= c_start;
          fl_q <= '0;
          fk_q <= '0;
          for (int k = 0; k < 3; k++) take_q[k] <= '0;
        end
        edd_pkg::ST_FLUSH: begin
          fl_q <= fl_q + 3'd1;
          if (fl_q == 3'd4) begin
            for (int k = 0; k < 5; k++) win_q[k] <= '0;
          end
        end
        edd_pkg::ST_FETCH: begin
          rd_addr_q <= mem_raddr;
          if (!need_rd) begin
            if (!win_q[fk_q].vld) begin
              win_q[fk_q] <= '0;
            end
            fk_q <= fk_q + 3'd1;
          end
        end
        edd_pkg::ST_FWAIT: begin
          if (take_f) begin
            // taking a column: next-row sum becomes the carried error
            win_q[fk_q] <= {1'b1, rd_addr_q, mem_rdata_q[11:0], 12'd0};
            take_q[2'(fk_q - 3'd2)] <= $signed(mem_rdata_q[23:12]);
          end else begin
            win_q[fk_q] <= {1'b1, rd_addr_q, mem_rdata_q};
          end
          fk_q <= fk_q + 3'd1;
        end
        edd_pkg::ST_STEP: begin
          v_q       <= v_sat;
          step_q    <= 8'(step_prod >> 16);
          div_rem_q <= '0;
          div_quo_q <= v_sat;
          div_cnt_q <= '0;
        end
        edd_pkg::ST_DIV: begin
          div_rem_q <= div_rem_n;
          div_quo_q <= {div_quo_q[6:0], div_bit};
          div_cnt_q <= div_cnt_q + 3'd1;
        end
        edd_pkg::ST_ROUND: begin
          kq_q <= (k_rnd > {1'b0, n_lvl}) ? n_lvl : k_rnd[7:0];
        end
        edd_pkg::ST_MUL: begin
          if (bits_eff == 4'd8) begin
            q_q <= v_q;
          end else if (bits_eff == 4'd7) begin
            q_q <= {v_q[7:1], 1'b0};
          end else if (step_q == '0) begin
            q_q <= '0;
          end else begin
            q_q <= q_prod[7:0];
          end
        end
        edd_pkg::ST_SHARE: begin
          for (int k = 0; k < 12; k++) begin
            sh_q[k] <= edd_pkg::share(err, kw[k], ks_q);
          end
        end
        edd_pkg::ST_UPDATE: begin
          if (go) begin
            out_vld_q  <= 1'b1;
            out_q      <= q_q;
            ahead_q[0] <= a1 + ((c_next < w_eff) ? sh_q[0] : 12'sd0);
            ahead_q[1] <= a2 + ((CKW'(c_q) + CKW'(2) < CKW'(w_eff)) ? sh_q[1] : 12'sd0);
            // advance the window by one column; the leftmost one is written back
            for (int k = 0; k < 4; k++) win_q[k] <= win_upd[k + 1];
            win_q[4] <= '0;
            col_q <= (c_next >= w_eff) ? '0 : AW'(c_next);
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_no_mem_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("error memory read and written in one cycle");

  a_frame_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> (state_q == edd_pkg::ST_CLEAR))
    else $error("frame start did not begin a clearing pass");

  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == edd_pkg::ST_UPDATE))
    else $error("result raised outside the update step");
`endif

endmodule

### tb/sv/error_diffusion_dither_core_tb.sv
// Self-checking testbench for the error-diffusion dither core: directed and random stream traffic and predictor.
module error_diffusion_dither_core_tb;

  localparam int MaxW = 2048;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] pixel;
  } pix_t;

  typedef struct packed {
    logic [edd_pkg::CfgIdxW-1:0]  idx;
    logic [edd_pkg::CfgDataW-1:0] data;
  } cfg_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [edd_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [edd_pkg::CfgDataW-1:0] cfg_data_i = '0;

  error_diffusion_dither_core dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predictor state and registers
  int unsigned line_width = 640;
  int unsigned level_bits = 1;
  int unsigned kernel_sel = 0;
  int unsigned max_val = 255;
  int err_next[MaxW];
  int err_after[MaxW];
  int ahead[2];
  int unsigned column;

  pix_t pixel_q[$];
  cfg_t reg_write_q[$];
  logic [7:0] level_q[$];
  int failures = 0;
  bit no_idle = 0;
  bit long_hold_req = 0;
  bit long_hold_done = 0;
  int idle_cycles = 0;

  function automatic int take_col(int x);
    int v;
    v = err_next[x];
    err_next[x] = err_after[x];
    err_after[x] = 0;
    return v;
  endfunction

  function automatic int quantize(int v);
    int bits, n, stp, k, rem;
    bits = (level_bits == 0) ? 1 : int'(level_bits);
    if (bits >= 8) return v;
    if (bits == 7) return v & ~1;
    n = (1 << bits) - 1;
    stp = int'(max_val) / n;
    if (stp == 0) return 0;
    k = v / stp;
    rem = v % stp;
    if (2 * rem > stp) k++;
    if (k > n) k = n;
    return k * stp;
  endfunction

  function automatic logic [7:0] dither_pixel(pix_t it);
    int divs[4] = '{16, 48, 32, 8};
    int rw[4][2] = '{'{7, 0}, '{7, 5}, '{5, 3}, '{1, 1}};
    int r1[4][5] = '{'{0, 3, 5, 1, 0}, '{3, 5, 7, 5, 3}, '{2, 4, 5, 4, 2}, '{0, 1, 1, 1, 0}};
    int r2[4][5] = '{'{0, 0, 0, 0, 0}, '{1, 3, 5, 3, 1}, '{0, 2, 3, 2, 0}, '{0, 0, 1, 0, 0}};
    int w, c, a0, a1, a2, v, q, e, x, d, ks;
    ks = int'(kernel_sel & 3);
    d = divs[ks];
    w = int'(line_width);
    if (w == 0) w = 1;
    if (w > MaxW) w = MaxW;
    if (it.frame_start) begin
      foreach (err_next[i]) begin
        err_next[i] = 0;
        err_after[i] = 0;
      end
      ahead[0] = 0;
      ahead[1] = 0;
      column = 0;
    end
    c = int'(column);
    if (c >= w) c = 0;
    if (c == 0) begin
      a0 = take_col(0);
      a1 = (1 < w) ? take_col(1) : 0;
    end else begin
      a0 = ahead[0];
      a1 = ahead[1];
    end
    a2 = (c + 2 < w) ? take_col(c + 2) : 0;
    v = int'(it.pixel) + a0;
    if (v < 0) v = 0;
    if (v > int'(max_val)) v = int'(max_val);
    q = quantize(v);
    e = v - q;
    if (c + 1 < w) a1 += e * rw[ks][0] / d;
    if (c + 2 < w) a2 += e * rw[ks][1] / d;
    for (int dx = -2; dx <= 2; dx++) begin
      x = c + dx;
      if (x >= 0 && x < w) begin
        err_next[x] += e * r1[ks][dx + 2] / d;
        err_after[x] += e * r2[ks][dx + 2] / d;
      end
    end
    ahead[0] = a1;
    ahead[1] = a2;
    c++;
    if (c >= w) c = 0;
    column = c;
    return q[7:0];
  endfunction

  // register writes: apply to the predictor on each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          edd_pkg::REG_LINE_WIDTH:    line_width = cfg_data_i;
          edd_pkg::REG_LEVEL_BITS:    level_bits = cfg_data_i & 12'hF;
          edd_pkg::REG_KERNEL_SELECT: kernel_sel = cfg_data_i & 12'h3;
          edd_pkg::REG_MAX_VALUE:     max_val = cfg_data_i & 12'hFF;
          default: ;
        endcase
        void'(reg_write_q.pop_front());
      end
      if (reg_write_q.size() > 0) begin
        cfg_valid_i <= 1'b1;
        cfg_index_i <= reg_write_q[0].idx;
        cfg_data_i  <= reg_write_q[0].data;
      end else begin
        cfg_valid_i <= 1'b0;
      end
    end
  end

  // pixel driver
  int src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      logic fire;
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) level_q.push_back(dither_pixel(pixel_q.pop_front()));
      if (!s_axis_tvalid || fire) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 5);
          s_axis_tvalid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pixel_q[0].pixel;
          s_axis_tuser  <= pixel_q[0].frame_start;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  int sink_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (level_q.size() == 0) begin
          $error("unexpected result pixel_out=%0d", m_axis_tdata);
          failures++;
        end else begin
          logic [7:0] exp_lvl;
          exp_lvl = level_q.pop_front();
          if (m_axis_tdata !== exp_lvl) begin
            $error("pixel_out expected %0d actual %0d", exp_lvl, m_axis_tdata);
            failures++;
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1;
        sink_stall = 400;
        m_axis_tready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        sink_stall = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("error_diffusion_dither_core_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_regs(int w, int bits, int ks, int mv);
    reg_write_q.push_back('{edd_pkg::REG_LINE_WIDTH, edd_pkg::CfgDataW'(w)});
    reg_write_q.push_back('{edd_pkg::REG_LEVEL_BITS, edd_pkg::CfgDataW'(bits)});
    reg_write_q.push_back('{edd_pkg::REG_KERNEL_SELECT, edd_pkg::CfgDataW'(ks)});
    reg_write_q.push_back('{edd_pkg::REG_MAX_VALUE, edd_pkg::CfgDataW'(mv)});
    while (reg_write_q.size() > 0 || cfg_valid_i) @(posedge clk_i);
  endtask

  // wait for the stream to drain, then let the last pixel's work settle
  task automatic drain();
    while (pixel_q.size() > 0 || s_axis_tvalid || level_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic push_pix(int p, bit fs);
    pixel_q.push_back('{fs, p[7:0]});
  endtask

  initial begin
    int w, n, p;
    foreach (err_next[i]) begin
      err_next[i] = 0;
      err_after[i] = 0;
    end
    ahead[0] = 0;
    ahead[1] = 0;
    column = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, ties, saturation and row edges
    set_regs(3, 1, edd_pkg::KERN_FS, 255);
    push_pix(0, 1); push_pix(255, 0); push_pix(128, 0); push_pix(127, 0);
    push_pix(200, 0); push_pix(255, 0); push_pix(0, 0); push_pix(90, 0);
    drain();
    set_regs(1, 0, edd_pkg::KERN_ATK, 0);
    push_pix(255, 1); push_pix(17, 0); push_pix(255, 0);
    drain();
    set_regs(0, 15, edd_pkg::KERN_JJN, 1);
    push_pix(1, 1); push_pix(255, 0); push_pix(0, 0);
    drain();
    set_regs(4095, 7, edd_pkg::KERN_SIERRA, 100);
    push_pix(255, 1); push_pix(99, 0); push_pix(33, 0);
    drain();
    set_regs(5, 3, edd_pkg::KERN_JJN, 5);
    push_pix(3, 1); push_pix(200, 0); push_pix(4, 0);
    drain();
    // narrower width with no frame start: column past the new edge
    set_regs(2, 2, edd_pkg::KERN_FS, 255);
    push_pix(77, 0); push_pix(180, 0); push_pix(250, 0);
    drain();

    for (int ph = 0; ph < 32; ph++) begin
      if (ph == 27) no_idle = 1;
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 1);
        1:       w = $urandom_range(13, 300);
        2:       w = ($urandom_range(0, 1) != 0) ? 2048 : 4095;
        default: w = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 5))
        0:       p = 255;
        1:       p = $urandom_range(0, 3);
        default: p = $urandom_range(0, 255);
      endcase
      set_regs(w, $urandom_range(0, 15), $urandom_range(0, 3), p);
      if (ph == 4) long_hold_req = 1;
      n = $urandom_range(25, 40);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0:       p = 0;
          1:       p = 255;
          default: p = $urandom_range(0, 255);
        endcase
        push_pix(p, (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 39) == 0));
      end
      // pause the sender until all results are back
      drain();
    end

    if (failures == 0) begin
      $display("error_diffusion_dither_core_tb: PASS");
    end else begin
      $display("error_diffusion_dither_core_tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/edd_pkg.sv
hw/rtl/error_diffusion_dither_core.sv
tb/sv/error_diffusion_dither_core_tb.sv
